// File: rtl/alignment_residual_nll_accumulator_assert.svh
// Assertion macros shared by the checkers of the residual likelihood block.
`ifndef ALIGNMENT_RESIDUAL_NLL_ACCUMULATOR_ASSERT_SVH
`define ALIGNMENT_RESIDUAL_NLL_ACCUMULATOR_ASSERT_SVH

// The consequent must hold in the clock after the antecedent.
`define ARNLL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same clock as the antecedent.
`define ARNLL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checked through reset as well.
`define ARNLL_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/arnll_pkg.sv
`timescale 1ns / 1ps
package arnll_pkg;

    localparam int S_DATA_W   = 192;
    localparam int M_DATA_W   = 96;
    localparam int CFG_ADDR_W = 5;
    localparam int STEP_W     = 6;
    localparam int ACC_W      = 48;

    localparam logic [STEP_W-1:0] LAST_STEP_FULL  = 6'd36;
    localparam logic [STEP_W-1:0] LAST_STEP_XONLY = 6'd21;

    // 0.5*ln(2*pi) + ln(0.5) in Q32.32.
    localparam logic [64:0] TERM_CONST      = 65'd969766475;
    localparam logic [62:0] SUM_MAX         = {63{1'b1}};
    localparam logic [32:0] UNIT_Q16        = 33'd65536;
    localparam logic [31:0] TERM_WEIGHT_RST = 32'd131072;

    typedef enum logic [2:0] {
        REG_OFFSET_X     = 3'd0,
        REG_OFFSET_Y     = 3'd1,
        REG_OFFSET_Z     = 3'd2,
        REG_TILT_ABOUT_X = 3'd3,
        REG_TILT_ABOUT_Y = 3'd4,
        REG_TILT_ABOUT_Z = 3'd5,
        REG_X_ONLY_MODE  = 3'd6,
        REG_TERM_WEIGHT  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] offset_x;
        logic [31:0] offset_y;
        logic [31:0] offset_z;
        logic [31:0] tilt_about_x;
        logic [31:0] tilt_about_y;
        logic [31:0] tilt_about_z;
        logic        x_only_mode;
        logic [31:0] term_weight;
    } cfg_t;

    typedef enum logic [3:0] {
        A_ZERO, A_SX, A_SY, A_TX, A_TY, A_SXY, A_SXX1, A_SYY1,
        A_TYSX, A_TXSX, A_TYSY, A_TXSY, A_MAG, A_PHHI, A_SQLO
    } a_sel_t;

    typedef enum logic [3:0] {
        B_ZERO, B_SX, B_SY, B_OZ, B_TAX, B_TAY, B_TAZ, B_MAG, B_W
    } b_sel_t;

    typedef enum logic [3:0] {
        WB_NONE, WB_SXX, WB_SXY, WB_SYY, WB_TYSX, WB_TXSX, WB_TYSY, WB_TXSY,
        WB_INIT16, WB_INIT24, WB_ADD24, WB_SUB24, WB_SQ, WB_PH, WB_LO
    } wb_t;

    typedef enum logic [1:0] {
        BASE_DX, BASE_DXDZ, BASE_DY, BASE_DYDZ
    } base_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        wb_t    wb;
        base_t  base;
    } step_t;

    typedef struct packed {
        logic   load;
        logic   finish;
        a_sel_t a_sel;
        b_sel_t b_sel;
        wb_t    wb;
        base_t  base;
    } ctrl_t;

    // Microcode of one event. A product issued at one step is written back
    // during the following step, so a value is usable by the step after that at the earliest.
    function automatic step_t step_rom(input logic [STEP_W-1:0] idx);
        step_t s;
        s = '{A_ZERO, B_ZERO, WB_NONE, BASE_DX};
        case (idx)
            // Saturated Q16.16 products used by the predictions.
            6'd0:  s = '{A_SX,   B_SX,  WB_SXX,    BASE_DX};
            6'd1:  s = '{A_SX,   B_SY,  WB_SXY,    BASE_DX};
            6'd2:  s = '{A_TY,   B_SX,  WB_TYSX,   BASE_DX};
            6'd3:  s = '{A_TX,   B_SX,  WB_TXSX,   BASE_DX};
            6'd4:  s = '{A_TY,   B_SY,  WB_TYSY,   BASE_DX};
            6'd5:  s = '{A_TX,   B_SY,  WB_TXSY,   BASE_DX};
            6'd6:  s = '{A_SY,   B_SY,  WB_SYY,    BASE_DX};
            // dx residual
            6'd7:  s = '{A_SX,   B_OZ,  WB_INIT16, BASE_DX};
            6'd8:  s = '{A_TYSX, B_TAX, WB_ADD24,  BASE_DX};
            6'd9:  s = '{A_TXSX, B_TAY, WB_SUB24,  BASE_DX};
            6'd10: s = '{A_TY,   B_TAZ, WB_ADD24,  BASE_DX};
            6'd12: s = '{A_MAG,  B_MAG, WB_SQ,     BASE_DX};
            6'd13: s = '{A_PHHI, B_W,   WB_PH,     BASE_DX};
            6'd14: s = '{A_SQLO, B_W,   WB_LO,     BASE_DX};
            // dxdz residual
            6'd15: s = '{A_SXY,  B_TAX, WB_INIT24, BASE_DXDZ};
            6'd16: s = '{A_SXX1, B_TAY, WB_SUB24,  BASE_DXDZ};
            6'd17: s = '{A_SY,   B_TAZ, WB_ADD24,  BASE_DXDZ};
            6'd19: s = '{A_MAG,  B_MAG, WB_SQ,     BASE_DXDZ};
            6'd20: s = '{A_PHHI, B_W,   WB_PH,     BASE_DXDZ};
            6'd21: s = '{A_SQLO, B_W,   WB_LO,     BASE_DXDZ};
            // dy residual
            6'd22: s = '{A_SY,   B_OZ,  WB_INIT16, BASE_DY};
            6'd23: s = '{A_TYSY, B_TAX, WB_ADD24,  BASE_DY};
            6'd24: s = '{A_TXSY, B_TAY, WB_SUB24,  BASE_DY};
            6'd25: s = '{A_TX,   B_TAZ, WB_SUB24,  BASE_DY};
            6'd27: s = '{A_MAG,  B_MAG, WB_SQ,     BASE_DY};
            6'd28: s = '{A_PHHI, B_W,   WB_PH,     BASE_DY};
            6'd29: s = '{A_SQLO, B_W,   WB_LO,     BASE_DY};
            // dydz residual
            6'd30: s = '{A_SYY1, B_TAX, WB_INIT24, BASE_DYDZ};
            6'd31: s = '{A_SXY,  B_TAY, WB_SUB24,  BASE_DYDZ};
            6'd32: s = '{A_SX,   B_TAZ, WB_SUB24,  BASE_DYDZ};
            6'd34: s = '{A_MAG,  B_MAG, WB_SQ,     BASE_DYDZ};
            6'd35: s = '{A_PHHI, B_W,   WB_PH,     BASE_DYDZ};
            6'd36: s = '{A_SQLO, B_W,   WB_LO,     BASE_DYDZ};
            default: s = '{A_ZERO, B_ZERO, WB_NONE, BASE_DX};
        endcase
        return s;
    endfunction

endpackage

// File: rtl/arnll_seq.sv
`timescale 1ns / 1ps
module arnll_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           x_only,
    input  logic           last_event,
    input  logic           out_busy,
    output logic           s_tready,
    output arnll_pkg::ctrl_t ctrl
);
    import arnll_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    step_t             rom;
    logic              last_step;

    assign rom       = step_rom(step_reg);
    assign last_step = (step_reg == (x_only ? LAST_STEP_XONLY : LAST_STEP_FULL));
    assign s_tready  = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        ctrl        = '{1'b0, 1'b0, A_ZERO, B_ZERO, WB_NONE, BASE_DX};
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctrl.load  = 1'b1;
                    step_next  = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                ctrl.a_sel = rom.a_sel;
                ctrl.b_sel = rom.b_sel;
                ctrl.wb    = rom.wb;
                ctrl.base  = rom.base;
                step_next  = step_reg + 1'b1;
                if (last_step) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // Lets the final term land in the running sum.
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!(last_event && out_busy)) begin
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: rtl/arnll_datapath.sv
`timescale 1ns / 1ps
module arnll_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  arnll_pkg::ctrl_t                ctrl,
    input  arnll_pkg::cfg_t                 cfg,
    input  logic [arnll_pkg::S_DATA_W-1:0]  in_data,
    input  logic                            in_last,
    output logic                            last_event,
    output logic [62:0]                     res_sum,
    output logic [31:0]                     res_count
);
    import arnll_pkg::*;

    // Captured event.
    logic [31:0] mdx_reg, mdy_reg, sx_reg, sy_reg, tx_reg, ty_reg;
    logic        last_reg;

    // Saturated Q16.16 intermediate products.
    logic [31:0] sxx_reg, sxy_reg, syy_reg, tysx_reg, txsx_reg, tysy_reg, txsy_reg;

    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod_next, prod_reg;
    wb_t                wb_reg;
    base_t              base_reg;

    logic [ACC_W-1:0] acc_reg, acc_next, base_val, acc_abs;
    logic [ACC_W-1:0] sh16, sh24;
    logic [31:0]      mag;
    logic [49:0]      pm_wide;
    logic [31:0]      pm_sat;

    logic [31:0] sqlo_reg;
    logic [63:0] pre_reg, pre_next;
    logic        big_reg, big_next;
    logic [64:0] total;
    logic [62:0] sum_reg, sum_next;
    logic [31:0] count_reg, count_next, count_inc;

    // Magnitude of the residual, capped to 32 bits.
    assign acc_abs = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign mag     = (|acc_abs[ACC_W-1:32]) ? 32'hFFFF_FFFF : acc_abs[31:0];

    always_comb begin
        case (ctrl.a_sel)
            A_SX:    op_a = {sx_reg[31], sx_reg};
            A_SY:    op_a = {sy_reg[31], sy_reg};
            A_TX:    op_a = {tx_reg[31], tx_reg};
            A_TY:    op_a = {ty_reg[31], ty_reg};
            A_SXY:   op_a = {sxy_reg[31], sxy_reg};
            A_SXX1:  op_a = {sxx_reg[31], sxx_reg} + UNIT_Q16;
            A_SYY1:  op_a = {syy_reg[31], syy_reg} + UNIT_Q16;
            A_TYSX:  op_a = {tysx_reg[31], tysx_reg};
            A_TXSX:  op_a = {txsx_reg[31], txsx_reg};
            A_TYSY:  op_a = {tysy_reg[31], tysy_reg};
            A_TXSY:  op_a = {txsy_reg[31], txsy_reg};
            A_MAG:   op_a = {1'b0, mag};
            A_PHHI:  op_a = {1'b0, prod_reg[63:32]};
            A_SQLO:  op_a = {1'b0, sqlo_reg};
            default: op_a = '0;
        endcase
        case (ctrl.b_sel)
            B_SX:    op_b = {sx_reg[31], sx_reg};
            B_SY:    op_b = {sy_reg[31], sy_reg};
            B_OZ:    op_b = {cfg.offset_z[31], cfg.offset_z};
            B_TAX:   op_b = {cfg.tilt_about_x[31], cfg.tilt_about_x};
            B_TAY:   op_b = {cfg.tilt_about_y[31], cfg.tilt_about_y};
            B_TAZ:   op_b = {cfg.tilt_about_z[31], cfg.tilt_about_z};
            B_MAG:   op_b = {1'b0, mag};
            B_W:     op_b = {1'b0, cfg.term_weight};
            default: op_b = '0;
        endcase
    end

    assign prod_next = op_a * op_b;

    // Writeback views of the registered product.
    assign pm_wide = prod_reg[65:16];
    always_comb begin
        if (pm_wide[49] && !(&pm_wide[48:31])) begin
            pm_sat = 32'h8000_0000;
        end else if (!pm_wide[49] && (|pm_wide[48:31])) begin
            pm_sat = 32'h7FFF_FFFF;
        end else begin
            pm_sat = pm_wide[31:0];
        end
    end
    assign sh16 = prod_reg[63:16];
    assign sh24 = {{(ACC_W-42){prod_reg[65]}}, prod_reg[65:24]};

    always_comb begin
        case (base_reg)
            BASE_DX:   base_val = {{16{mdx_reg[31]}}, mdx_reg}
                                - {{16{cfg.offset_x[31]}}, cfg.offset_x};
            BASE_DXDZ: base_val = {{16{sx_reg[31]}}, sx_reg};
            BASE_DY:   base_val = {{16{mdy_reg[31]}}, mdy_reg}
                                - {{16{cfg.offset_y[31]}}, cfg.offset_y};
            BASE_DYDZ: base_val = {{16{sy_reg[31]}}, sy_reg};
            default:   base_val = '0;
        endcase
    end

    always_comb begin
        case (wb_reg)
            WB_INIT16: acc_next = base_val + sh16;
            WB_INIT24: acc_next = base_val + sh24;
            WB_ADD24:  acc_next = acc_reg + sh24;
            WB_SUB24:  acc_next = acc_reg - sh24;
            default:   acc_next = acc_reg;
        endcase
    end

    // The weighted square is split in a high and a low half product. Every
    // saturation point composes to one clamp of the running total.
    assign big_next  = |prod_reg[63:47];
    assign pre_next  = {1'b0, sum_reg} + {1'b0, prod_reg[46:0], 16'b0};
    assign total     = {1'b0, pre_reg} + {17'b0, prod_reg[63:16]} + TERM_CONST;
    assign count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (wb_reg == WB_LO) begin
            sum_next = (big_reg || (|total[64:63])) ? SUM_MAX : total[62:0];
        end
        if (ctrl.finish) begin
            if (last_reg) begin
                sum_next   = '0;
                count_next = '0;
            end else begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_reg    <= WB_NONE;
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            wb_reg    <= ctrl.wb;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        base_reg <= ctrl.base;
        acc_reg  <= acc_next;
        if (ctrl.load) begin
            mdx_reg  <= in_data[31:0];
            mdy_reg  <= in_data[63:32];
            sx_reg   <= in_data[95:64];
            // The x-only form treats the y slope as zero throughout.
            sy_reg   <= cfg.x_only_mode ? 32'd0 : in_data[127:96];
            tx_reg   <= in_data[159:128];
            ty_reg   <= in_data[191:160];
            last_reg <= in_last;
        end
        case (wb_reg)
            WB_SXX:  sxx_reg  <= pm_sat;
            WB_SXY:  sxy_reg  <= pm_sat;
            WB_SYY:  syy_reg  <= pm_sat;
            WB_TYSX: tysx_reg <= pm_sat;
            WB_TXSX: txsx_reg <= pm_sat;
            WB_TYSY: tysy_reg <= pm_sat;
            WB_TXSY: txsy_reg <= pm_sat;
            WB_SQ:   sqlo_reg <= prod_reg[31:0];
            WB_PH: begin
                pre_reg <= pre_next;
                big_reg <= big_next;
            end
            default: begin
            end
        endcase
    end

    assign last_event = last_reg;
    assign res_sum    = sum_reg;
    assign res_count  = count_inc;

endmodule

// File: rtl/alignment_residual_nll_accumulator.sv
`timescale 1ns / 1ps
// Accumulates the Gaussian negative log-likelihood of alignment residuals over
// a run of track events. Each event predicts the dx, dxdz, dy and dydz
// residuals from the six alignment registers, squares the differences,
// weights them by term_weight and adds them, plus a fixed per-term constant,
// to a saturating unsigned Q31.32 sum; x_only_mode keeps only the two x
// terms. An event with tlast set closes the run: one result with the sum and
// the event count is sent and both are cleared. All multiplications go
// through a single 33x33 multiplier that produces one product per clock
// while an event is processed, and the block takes no new event before it
// is through with the last one; s_tready is low during that time. The result
// of a closing event is held back while a previous result still waits on
// m_tready. The user must write configuration registers only while the
// block is idle; the block itself does not enforce it.
module alignment_residual_nll_accumulator (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Event request.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // meas_dx, meas_dy, meas_dxdz, meas_dydz, track_x, track_y (32 bits each)
    input  logic [arnll_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    // Result request.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // nll_sum [62:0], event_count [94:63], zero pad [95]
    output logic [arnll_pkg::M_DATA_W-1:0]     m_tdata,
    // Register port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [arnll_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import arnll_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    reg_idx_t    reg_idx;
    logic        cfg_wr;
    ctrl_t       ctrl;
    logic        dp_last;
    logic [62:0] res_sum;
    logic [31:0] res_count;
    logic        out_busy;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_OFFSET_X:     cfg_next.offset_x     = pwdata;
                REG_OFFSET_Y:     cfg_next.offset_y     = pwdata;
                REG_OFFSET_Z:     cfg_next.offset_z     = pwdata;
                REG_TILT_ABOUT_X: cfg_next.tilt_about_x = pwdata;
                REG_TILT_ABOUT_Y: cfg_next.tilt_about_y = pwdata;
                REG_TILT_ABOUT_Z: cfg_next.tilt_about_z = pwdata;
                REG_X_ONLY_MODE:  cfg_next.x_only_mode  = pwdata[0];
                REG_TERM_WEIGHT:  cfg_next.term_weight  = pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OFFSET_X:     prdata = cfg_reg.offset_x;
            REG_OFFSET_Y:     prdata = cfg_reg.offset_y;
            REG_OFFSET_Z:     prdata = cfg_reg.offset_z;
            REG_TILT_ABOUT_X: prdata = cfg_reg.tilt_about_x;
            REG_TILT_ABOUT_Y: prdata = cfg_reg.tilt_about_y;
            REG_TILT_ABOUT_Z: prdata = cfg_reg.tilt_about_z;
            REG_X_ONLY_MODE:  prdata = {31'b0, cfg_reg.x_only_mode};
            REG_TERM_WEIGHT:  prdata = cfg_reg.term_weight;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0,
                         TERM_WEIGHT_RST};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign out_busy = m_tvalid_reg && !m_tready;

    arnll_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .x_only     (cfg_reg.x_only_mode),
        .last_event (dp_last),
        .out_busy   (out_busy),
        .s_tready   (s_tready),
        .ctrl       (ctrl)
    );

    arnll_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .cfg        (cfg_reg),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .last_event (dp_last),
        .res_sum    (res_sum),
        .res_count  (res_count)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (ctrl.finish && dp_last) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.finish && dp_last) begin
            m_tdata_reg <= {1'b0, res_count, res_sum};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/arnll_checker.sv
`timescale 1ns / 1ps
`include "alignment_residual_nll_accumulator_assert.svh"
module arnll_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [arnll_pkg::M_DATA_W-1:0]     m_tdata
);

    // An accepted event makes the block busy.
    `ARNLL_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "block ready right after accepting an event")

    // A stalled result holds.
    `ARNLL_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // A result always counts the closing event and keeps the pad bit clear.
    `ARNLL_ASSERT_NOW(a_count_nonzero, aclk, aresetn, m_tvalid, (m_tdata[94:63] != 32'd0) && !m_tdata[95], "result with zero event count or set pad bit")

    // Reset leaves the block idle with no result pending.
    `ARNLL_ASSERT_ALWAYS_NEXT(a_reset_idle, aclk, !aresetn, s_tready && !m_tvalid, "block not idle after reset")

endmodule

bind alignment_residual_nll_accumulator arnll_checker u_arnll_checker (.*);

// File: tb/sv/nll_run_checker.sv
`timescale 1ns / 1ps
module nll_run_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // meas_dx, meas_dy, meas_dxdz, meas_dydz, track_x, track_y (32 bits each)
    input  logic [arnll_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // nll_sum [62:0], event_count [94:63], zero pad [95]
    input  logic [arnll_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [arnll_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                      pwdata,
    input  logic                             pready,
    output int                               mismatch_count,
    output int                               runs_awaited,
    output int                               runs_closed
);

    localparam logic [63:0] SUM_CEIL    = {1'b0, arnll_pkg::SUM_MAX};
    localparam logic [63:0] TERM_OFFSET = 64'(arnll_pkg::TERM_CONST);
    localparam longint      UNIT_ONE    = longint'(arnll_pkg::UNIT_Q16);
    localparam longint      Q16_MAX     = 64'sd2147483647;
    localparam longint      Q16_MIN     = -Q16_MAX - 1;

    typedef struct {
        longint      shift_x;
        longint      shift_y;
        longint      shift_z;
        longint      rot_x;
        longint      rot_y;
        longint      rot_z;
        logic        x_only;
        logic [31:0] weight;
    } alignment_t;

    typedef struct packed {
        logic [31:0] events;
        logic [62:0] nll;
    } run_total_t;

    alignment_t  geom;
    logic [63:0] open_sum;
    logic [31:0] open_events;
    run_total_t  closed_runs[$];
    int          failures = 0;
    int          closed = 0;

    // Q16.16 product, floored and clamped to the signed 32 bit range.
    function automatic longint q16_product(input longint a, input longint b);
        longint p;
        p = (a * b) >>> 16;
        if (p > Q16_MAX) p = Q16_MAX;
        else if (p < Q16_MIN) p = Q16_MIN;
        return p;
    endfunction

    // Q16.16 value times a Q8.24 angle gives Q16.16, without clamping.
    function automatic longint angle_product(input longint a, input longint ang);
        return (a * ang) >>> 24;
    endfunction

    function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > SUM_CEIL) ? SUM_CEIL : s;
    endfunction

    function automatic logic [63:0] residual_cost(input longint measured,
                                                  input longint predicted);
        longint      diff;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] w;
        logic [63:0] scaled_hi;
        logic [63:0] cost;
        diff = measured - predicted;
        mag = (diff < 0) ? -diff : diff;
        if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
        sq = mag * mag;
        w = {32'd0, geom.weight};
        // The upper half of the square is weighted first; if that alone
        // overflows the Q31.32 sum range the whole term pins at the ceiling.
        scaled_hi = (sq >> 32) * w;
        if (scaled_hi >= 64'h0000_8000_0000_0000) return SUM_CEIL;
        cost = (scaled_hi << 16) + (({32'd0, sq[31:0]} * w) >> 16);
        if (cost > SUM_CEIL) cost = SUM_CEIL;
        return sum_sat(cost, TERM_OFFSET);
    endfunction

    function automatic logic [63:0] event_likelihood(input logic [arnll_pkg::S_DATA_W-1:0] d);
        longint      meas_x;
        longint      meas_y;
        longint      slope_x;
        longint      slope_y;
        longint      pos_x;
        longint      pos_y;
        longint      slope_xy;
        longint      pred_x;
        longint      pred_xz;
        longint      pred_y;
        longint      pred_yz;
        logic [63:0] total;
        meas_x  = $signed(d[31:0]);
        meas_y  = $signed(d[63:32]);
        slope_x = $signed(d[95:64]);
        slope_y = $signed(d[127:96]);
        pos_x   = $signed(d[159:128]);
        pos_y   = $signed(d[191:160]);
        if (geom.x_only) slope_y = 0;
        slope_xy = q16_product(slope_x, slope_y);

        pred_x = geom.shift_x - ((slope_x * geom.shift_z) >>> 16)
               - angle_product(q16_product(pos_y, slope_x), geom.rot_x)
               + angle_product(q16_product(pos_x, slope_x), geom.rot_y)
               - angle_product(pos_y, geom.rot_z);
        pred_xz = -angle_product(slope_xy, geom.rot_x)
                + angle_product(UNIT_ONE + q16_product(slope_x, slope_x), geom.rot_y)
                - angle_product(slope_y, geom.rot_z);
        total = sum_sat(residual_cost(meas_x, pred_x), residual_cost(slope_x, pred_xz));

        if (!geom.x_only) begin
            pred_y = geom.shift_y - ((slope_y * geom.shift_z) >>> 16)
                   - angle_product(q16_product(pos_y, slope_y), geom.rot_x)
                   + angle_product(q16_product(pos_x, slope_y), geom.rot_y)
                   + angle_product(pos_x, geom.rot_z);
            pred_yz = -angle_product(UNIT_ONE + q16_product(slope_y, slope_y), geom.rot_x)
                    + angle_product(slope_xy, geom.rot_y)
                    + angle_product(slope_x, geom.rot_z);
            total = sum_sat(total, residual_cost(meas_y, pred_y));
            total = sum_sat(total, residual_cost(slope_y, pred_yz));
        end
        return total;
    endfunction

    always @(posedge aclk) begin : watch
        run_total_t want;
        run_total_t got;
        if (!aresetn) begin
            geom.shift_x = 0;
            geom.shift_y = 0;
            geom.shift_z = 0;
            geom.rot_x = 0;
            geom.rot_y = 0;
            geom.rot_z = 0;
            geom.x_only = 1'b0;
            geom.weight = arnll_pkg::TERM_WEIGHT_RST;
            open_sum = '0;
            open_events = '0;
            closed_runs.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.nll = m_tdata[62:0];
                got.events = m_tdata[94:63];
                if (closed_runs.size() == 0) begin
                    $display("%0t: result request with no closed run pending: %s %h, %s %0d",
                             $time, "nll_sum", got.nll, "event_count", got.events);
                    failures++;
                end else begin
                    want = closed_runs.pop_front();
                    if (got.nll !== want.nll) begin
                        $display("%0t: nll_sum expected %h, actual %h",
                                 $time, want.nll, got.nll);
                        failures++;
                    end
                    if (got.events !== want.events) begin
                        $display("%0t: event_count expected %0d, actual %0d",
                                 $time, want.events, got.events);
                        failures++;
                    end
                end
            end

            if (psel && penable && pwrite && pready) begin
                case (arnll_pkg::reg_idx_t'(paddr[4:2]))
                    arnll_pkg::REG_OFFSET_X:     geom.shift_x = $signed(pwdata);
                    arnll_pkg::REG_OFFSET_Y:     geom.shift_y = $signed(pwdata);
                    arnll_pkg::REG_OFFSET_Z:     geom.shift_z = $signed(pwdata);
                    arnll_pkg::REG_TILT_ABOUT_X: geom.rot_x = $signed(pwdata);
                    arnll_pkg::REG_TILT_ABOUT_Y: geom.rot_y = $signed(pwdata);
                    arnll_pkg::REG_TILT_ABOUT_Z: geom.rot_z = $signed(pwdata);
                    arnll_pkg::REG_X_ONLY_MODE:  geom.x_only = pwdata[0];
                    arnll_pkg::REG_TERM_WEIGHT:  geom.weight = pwdata;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                open_sum = sum_sat(open_sum, event_likelihood(s_tdata));
                if (open_events != 32'hFFFF_FFFF) open_events++;
                if (s_tlast) begin
                    want.nll = open_sum[62:0];
                    want.events = open_events;
                    closed_runs.push_back(want);
                    open_sum = '0;
                    open_events = '0;
                    closed++;
                end
            end
        end
        mismatch_count <= failures;
        runs_awaited <= closed_runs.size();
        runs_closed <= closed;
    end

endmodule

// File: tb/sv/alignment_residual_nll_accumulator_test.sv
`timescale 1ns / 1ps
module alignment_residual_nll_accumulator_test;

    localparam int QUIET_LIMIT      = 3000;
    localparam int SETTLE_CYCLES    = 60;
    localparam int RANDOM_PHASES    = 12;
    localparam int EVENTS_PER_PHASE = 117;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MIN = 32'h8000_0000;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [arnll_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic                             s_tlast = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [arnll_pkg::M_DATA_W-1:0]   m_tdata;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [arnll_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]                      pwdata = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    int mismatch_count;
    int runs_awaited;
    int runs_closed;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int events_sent = 0;
    int settings_loaded = 0;

    always #6 aclk = ~aclk;

    alignment_residual_nll_accumulator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    nll_run_checker nll_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .runs_awaited   (runs_awaited),
        .runs_closed    (runs_closed)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Any request on any port counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input arnll_pkg::reg_idx_t r, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_alignment(input logic [31:0] shift_x, input logic [31:0] shift_y,
                                  input logic [31:0] shift_z, input logic [31:0] rot_x,
                                  input logic [31:0] rot_y, input logic [31:0] rot_z,
                                  input logic x_only, input logic [31:0] weight);
        write_reg(arnll_pkg::REG_OFFSET_X, shift_x);
        write_reg(arnll_pkg::REG_OFFSET_Y, shift_y);
        write_reg(arnll_pkg::REG_OFFSET_Z, shift_z);
        write_reg(arnll_pkg::REG_TILT_ABOUT_X, rot_x);
        write_reg(arnll_pkg::REG_TILT_ABOUT_Y, rot_y);
        write_reg(arnll_pkg::REG_TILT_ABOUT_Z, rot_z);
        write_reg(arnll_pkg::REG_X_ONLY_MODE, {31'd0, x_only});
        write_reg(arnll_pkg::REG_TERM_WEIGHT, weight);
        settings_loaded++;
    endtask

    task automatic send_event(input logic [31:0] dx, input logic [31:0] dy,
                              input logic [31:0] dxdz, input logic [31:0] dydz,
                              input logic [31:0] track_x, input logic [31:0] track_y,
                              input logic closing);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {track_y, track_x, dydz, dxdz, dy, dx};
        s_tlast <= closing;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        events_sent++;
    endtask

    // Lets every closed run come out and the block go idle before the
    // registers change; an open run simply carries over.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (runs_awaited != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(3))
            0:       return NEG_MIN;
            1:       return POS_MAX;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Mostly values of a few centimetres so the sum stays meaningful, with
    // full-range and boundary values mixed in.
    function automatic logic [31:0] field_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(262143) - 32'd131072;
            4, 5:       return $urandom_range(33554431) - 32'd16777216;
            6, 7:       return $urandom;
            8:          return extreme_value();
            default:    return $urandom_range(511) - 32'd256;
        endcase
    endfunction

    function automatic logic [31:0] alignment_value();
        case ($urandom_range(7))
            0, 1, 2, 3, 4: return $urandom_range(2097151) - 32'd1048576;
            5:             return $urandom;
            6:             return 32'h0000_0000;
            default:       return extreme_value();
        endcase
    endfunction

    function automatic logic [31:0] weight_value();
        case ($urandom_range(7))
            0, 1:    return arnll_pkg::TERM_WEIGHT_RST;
            2, 3, 4: return $urandom_range(1048576);
            5:       return 32'h0000_0000;
            6:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic int run_length();
        if ($urandom_range(9) == 0) return $urandom_range(40, 12);
        return $urandom_range(8, 1);
    endfunction

    initial begin : stimulus
        int   phase;
        int   n;
        int   left_in_run;
        logic closing;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: zero alignment, weight 2.0, full form.
        send_event(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        send_event(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000,
                   32'h000A_0000, 32'hFFF6_0000, 1'b0);
        send_event(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b0);
        send_event(NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, 1'b1);
        send_event(NEG_MIN, POS_MAX, POS_MAX, NEG_MIN, NEG_MIN, POS_MAX, 1'b0);
        send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        drain();

        // Extreme alignment with zero weight: only the fixed constant counts.
        load_alignment(POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, 1'b0, 32'h0);
        send_event(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                   32'h0001_0000, 32'h0001_0000, 1'b0);
        send_event(POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, 1'b1);
        send_event(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        drain();

        // x-only form with the heaviest weight; the y slope must be ignored.
        load_alignment(NEG_MIN, POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, POS_MAX, 1'b1,
                       32'hFFFF_FFFF);
        send_event(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        send_event(32'h0000_0010, 32'h0, 32'h0000_0010, 32'h0, 32'h0, 32'h0, 1'b0);
        send_event(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b0);
        send_event(32'h0, 32'h0, 32'h0, POS_MAX, 32'h0, 32'h0, 1'b1);
        drain();

        // Small realistic misalignment, weight 1.0.
        load_alignment(32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000, 32'h0000_1000,
                       32'hFFFF_F000, 32'h0000_0800, 1'b0, 32'h0001_0000);
        send_event(32'h0000_3800, 32'hFFFF_C400, 32'h0000_0200, 32'hFFFF_FE00,
                   32'h0014_0000, 32'hFFEC_0000, 1'b0);
        send_event(32'h0000_4200, 32'hFFFF_B800, 32'hFFFF_FF00, 32'h0000_0100,
                   32'hFFF0_0000, 32'h0008_0000, 1'b0);
        send_event(32'hFFFF_F000, 32'h0000_1000, 32'h0000_0080, 32'h0000_0040,
                   32'h0000_0000, 32'h0020_0000, 1'b0);
        send_event(32'h0000_4000, 32'hFFFF_C000, 32'h0, 32'h0, 32'h0001_0000,
                   32'h0001_0000, 1'b1);
        send_event(32'h0, 32'h0, POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, 1'b1);
        drain();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 78; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            load_alignment(alignment_value(), alignment_value(), alignment_value(),
                           alignment_value(), alignment_value(), alignment_value(),
                           1'($urandom_range(1)), weight_value());
            left_in_run = run_length();
            for (n = 0; n < EVENTS_PER_PHASE; n++) begin
                closing = (left_in_run == 1) ||
                          (phase == RANDOM_PHASES - 1 && n == EVENTS_PER_PHASE - 1);
                send_event(field_value(), field_value(), field_value(), field_value(),
                           field_value(), field_value(), closing);
                if (left_in_run == 1) left_in_run = run_length();
                else left_in_run--;
            end
            drain();
        end

        $display("Covered %0d events in %0d closed runs under %0d register settings,",
                 events_sent, runs_closed, settings_loaded);
        $display("full and x-only forms, saturating sums, and four idle and stall patterns.");
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
